[hdl/lfra_pkg.sv]
// ----------------------------------------------------------------------------
// Lowest free room allocator: shared package
// Types and constants used by the allocator core and its room file.
// ----------------------------------------------------------------------------
package lfra_pkg;

   // number of rooms held in the room file
   localparam int unsigned ROOMS  = 16;
   localparam int unsigned RIDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;

   localparam int unsigned TIME_W  = 48;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned IN_W    = 32;
   localparam int unsigned CFG_W   = 5;

   // reset value of the rooms-in-use register
   localparam logic [CFG_W-1:0] ROOMS_IN_USE_RESET = 5'd16;

   // register indexes on the configuration port
   localparam logic REG_ROOMS_IN_USE = 1'b0;

   typedef logic [RIDX_W-1:0]  room_idx_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [COUNT_W-1:0] count_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_BEST,
      ST_DONE
   } state_type;

   // write port of the room file
   typedef struct packed {
      logic         en;
      room_idx_type idx;
      time_type     free_at;
      count_type    uses;
   } room_wr_type;

endpackage

[hdl/lfra_room_file.sv]
// ----------------------------------------------------------------------------
// Lowest free room allocator: room file
// Free-at time and use count per room; one scan read, one pick read, one write.
// ----------------------------------------------------------------------------
module lfra_room_file (
   input  logic                  clock,
   input  logic                  reset,
   input  lfra_pkg::room_idx_type scan_idx,
   output lfra_pkg::time_type     scan_free_at,
   input  lfra_pkg::room_idx_type pick_idx,
   output lfra_pkg::count_type    pick_uses,
   input  lfra_pkg::room_wr_type  wr
);

   lfra_pkg::time_type  free_at_ff [lfra_pkg::ROOMS];
   lfra_pkg::count_type uses_ff    [lfra_pkg::ROOMS];

   // state update: reset clears every room
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < lfra_pkg::ROOMS; r++) begin
            free_at_ff[r] <= '0;
            uses_ff[r]    <= '0;
         end
      end else if (wr.en) begin
         free_at_ff[wr.idx] <= wr.free_at;
         uses_ff[wr.idx]    <= wr.uses;
      end
   end

   // read ports
   assign scan_free_at = free_at_ff[scan_idx];
   assign pick_uses    = uses_ff[pick_idx];

endmodule

[hdl/lowest_free_room_allocator_core.sv]
// ----------------------------------------------------------------------------
// Lowest free room allocator core
// Places each booking in the lowest free room, or delays it into the room that
// frees earliest; tracks use counts and the running most-booked room.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  start_time, end_time
//   rsp_      out        rsp_valid/rsp_ready  assigned_room, was_delayed,
//                                             actual_end, most_booked_room
//   csr       in         psel/penable/pready  rooms_in_use at addresses 0 to 3
//
// An accepted beat is scanned one room per cycle through a single compare
// unit, up to the first free room or the last room in use, then passes the
// update, best-room and hand-off states before the next beat can be taken.
// Reset is synchronous; it clears all rooms and the counts.
// req_ready is high only in idle; the result register lets a new beat be
// taken while the previous result still waits on rsp_ready.
// ----------------------------------------------------------------------------
module lowest_free_room_allocator_core (
   input  logic        clock,
   input  logic        reset,
   // booking requests
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_end_time,
   // allocation results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_assigned_room,
   output logic        rsp_was_delayed,
   output logic [47:0] rsp_actual_end,
   output logic [3:0]  rsp_most_booked_room,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   lfra_pkg::state_type    state_ff, state_in;
   logic [lfra_pkg::CFG_W-1:0] cfg_ff, cfg_in;
   logic [lfra_pkg::IN_W-1:0]  start_ff, start_in;
   logic [lfra_pkg::IN_W-1:0]  dur_ff, dur_in;
   lfra_pkg::room_idx_type idx_ff, idx_in;
   lfra_pkg::room_idx_type pick_ff, pick_in;
   lfra_pkg::time_type     early_ff, early_in;
   logic                   found_ff, found_in;
   lfra_pkg::time_type     fin_ff, fin_in;
   lfra_pkg::count_type    uses_ff, uses_in;
   lfra_pkg::room_idx_type best_room_ff, best_room_in;
   lfra_pkg::count_type    best_uses_ff, best_uses_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [3:0]             rsp_room_ff, rsp_room_in;
   logic                   rsp_delayed_ff, rsp_delayed_in;
   lfra_pkg::time_type     rsp_end_ff, rsp_end_in;
   logic [3:0]             rsp_best_ff, rsp_best_in;

   lfra_pkg::room_idx_type last_idx;
   lfra_pkg::time_type     scan_free_at;
   lfra_pkg::count_type    pick_uses;
   lfra_pkg::room_wr_type  wr;
   logic                   accept;
   logic                   load_rsp;
   logic                   fits;
   logic                   earlier;
   logic                   scan_end;
   logic [lfra_pkg::TIME_W:0] delay_sum;
   lfra_pkg::time_type     fin_calc;
   lfra_pkg::count_type    uses_inc;
   logic                   cfg_wr;

   // room file
   lfra_room_file u_room_file (
      .clock        (clock),
      .reset        (reset),
      .scan_idx     (idx_ff),
      .scan_free_at (scan_free_at),
      .pick_idx     (pick_ff),
      .pick_uses    (pick_uses),
      .wr           (wr)
   );

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lfra_pkg::REG_ROOMS_IN_USE);
   assign cfg_in = cfg_wr ? pwdata[lfra_pkg::CFG_W-1:0] : cfg_ff;
   assign prdata = (paddr[2] == lfra_pkg::REG_ROOMS_IN_USE) ?
                   {{(32-lfra_pkg::CFG_W){1'b0}}, cfg_ff} : 32'h0;

   // highest room index taking part
   always_comb begin
      if (cfg_ff == '0) begin
         last_idx = '0;
      end else if (32'(cfg_ff) > lfra_pkg::ROOMS) begin
         last_idx = lfra_pkg::room_idx_type'(lfra_pkg::ROOMS - 1);
      end else begin
         last_idx = lfra_pkg::room_idx_type'(cfg_ff - 5'd1);
      end
   end

   // shared compare unit: free by start, and earliest so far
   assign fits     = scan_free_at <= {16'h0, start_ff};
   assign earlier  = (idx_ff == '0) || (scan_free_at < early_ff);
   assign scan_end = fits || (idx_ff == last_idx);

   // new end time and saturating count
   assign delay_sum = {1'b0, early_ff} + {17'h0, dur_ff};
   always_comb begin
      if (found_ff) begin
         fin_calc = {16'h0, start_ff} + {16'h0, dur_ff};
      end else if (delay_sum[lfra_pkg::TIME_W]) begin
         fin_calc = '1;
      end else begin
         fin_calc = delay_sum[lfra_pkg::TIME_W-1:0];
      end
   end
   assign uses_inc = (pick_uses == '1) ? pick_uses : pick_uses + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfra_pkg::ST_IDLE: begin
            if (req_valid) state_in = lfra_pkg::ST_SCAN;
         end
         lfra_pkg::ST_SCAN: begin
            if (scan_end) state_in = lfra_pkg::ST_UPDATE;
         end
         lfra_pkg::ST_UPDATE: state_in = lfra_pkg::ST_BEST;
         lfra_pkg::ST_BEST:   state_in = lfra_pkg::ST_DONE;
         lfra_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = lfra_pkg::ST_IDLE;
         end
         default: state_in = lfra_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      wr        = '0;
      load_rsp  = 1'b0;
      case (state_ff)
         lfra_pkg::ST_IDLE: req_ready = 1'b1;
         lfra_pkg::ST_SCAN: ;
         lfra_pkg::ST_UPDATE: begin
            wr.en      = 1'b1;
            wr.idx     = pick_ff;
            wr.free_at = fin_calc;
            wr.uses    = uses_inc;
         end
         lfra_pkg::ST_BEST: ;
         lfra_pkg::ST_DONE: load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   // datapath next values
   always_comb begin
      start_in     = start_ff;
      dur_in       = dur_ff;
      idx_in       = idx_ff;
      pick_in      = pick_ff;
      early_in     = early_ff;
      found_in     = found_ff;
      fin_in       = fin_ff;
      uses_in      = uses_ff;
      best_room_in = best_room_ff;
      best_uses_in = best_uses_ff;
      // capture the beat and its duration
      if (accept) begin
         start_in = req_start_time;
         dur_in   = (req_end_time > req_start_time) ? req_end_time - req_start_time : '0;
         idx_in   = '0;
         pick_in  = '0;
         found_in = 1'b0;
      end
      // one room per cycle
      if (state_ff == lfra_pkg::ST_SCAN) begin
         if (fits) begin
            pick_in  = idx_ff;
            found_in = 1'b1;
         end else begin
            if (earlier) begin
               early_in = scan_free_at;
               pick_in  = idx_ff;
            end
            if (!scan_end) idx_in = lfra_pkg::room_idx_type'(idx_ff + 1'b1);
         end
      end
      if (wr.en) begin
         fin_in  = fin_calc;
         uses_in = uses_inc;
      end
      // running most-booked room
      if (state_ff == lfra_pkg::ST_BEST) begin
         if ((uses_ff > best_uses_ff) ||
             ((uses_ff == best_uses_ff) && (pick_ff < best_room_ff))) begin
            best_uses_in = uses_ff;
            best_room_in = pick_ff;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_room_in    = rsp_room_ff;
      rsp_delayed_in = rsp_delayed_ff;
      rsp_end_in     = rsp_end_ff;
      rsp_best_in    = rsp_best_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_room_in    = 4'(pick_ff);
         rsp_delayed_in = !found_ff;
         rsp_end_in     = fin_ff;
         rsp_best_in    = 4'(best_room_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfra_pkg::ST_IDLE;
         cfg_ff       <= lfra_pkg::ROOMS_IN_USE_RESET;
         best_room_ff <= '0;
         best_uses_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         best_room_ff <= best_room_in;
         best_uses_ff <= best_uses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff       <= start_in;
      dur_ff         <= dur_in;
      idx_ff         <= idx_in;
      pick_ff        <= pick_in;
      early_ff       <= early_in;
      found_ff       <= found_in;
      fin_ff         <= fin_in;
      uses_ff        <= uses_in;
      rsp_room_ff    <= rsp_room_in;
      rsp_delayed_ff <= rsp_delayed_in;
      rsp_end_ff     <= rsp_end_in;
      rsp_best_ff    <= rsp_best_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_assigned_room    = rsp_room_ff;
   assign rsp_was_delayed      = rsp_delayed_ff;
   assign rsp_actual_end       = rsp_end_ff;
   assign rsp_most_booked_room = rsp_best_ff;

   // checks
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfra_pkg::ST_SCAN) |-> (idx_ff <= last_idx))
      else $error("scan index beyond active rooms");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == lfra_pkg::ST_SCAN) && (idx_ff == '0)))
      else $error("accepted beat did not start a scan at room zero");

   a_free_end_fits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_delayed_ff) |-> (rsp_end_ff[47:32] == 16'h0))
      else $error("undelayed booking ends beyond the request range");

   a_room_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_room_ff <= 4'(last_idx)))
      else $error("booking placed in a room outside the allocation");

endmodule
